// ----- design/dct8_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct8_pkg
// Shared widths, fixed-point weights and the basis matrix of the 8-point
// orthonormal DCT-II / DCT-III core.
// ----------------------------------------------------------------------------
package dct8_pkg;

   // sample and weight precision
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 15;
   localparam int OUT_BITS       = 18;

   // datapath widths: weights stay below one half, so they fit in COEF_FRAC_BITS bits
   localparam int COEF_BITS = COEF_FRAC_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int PART_BITS = PROD_BITS + 2;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam int RND_BITS  = ACC_BITS + 1;

   localparam int N_POINTS = 8;
   localparam int N_TERMS  = N_POINTS * N_POINTS;
   localparam int N_PARTS  = N_POINTS * 2;

   // opcodes
   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   // weight quantisation: constants in units of 1e-9, scaled and rounded
   localparam longint WQ_SCALE = longint'(1) << COEF_FRAC_BITS;
   localparam longint WQ_DEN   = longint'(1000000000);
   localparam longint WQ_HALF  = longint'(500000000);

   localparam logic signed [COEF_BITS-1:0] K1 =
      COEF_BITS'((longint'(490392625) * WQ_SCALE + WQ_HALF) / WQ_DEN);
   localparam logic signed [COEF_BITS-1:0] K2 =
      COEF_BITS'((longint'(461939752) * WQ_SCALE + WQ_HALF) / WQ_DEN);
   localparam logic signed [COEF_BITS-1:0] K3 =
      COEF_BITS'((longint'(415734798) * WQ_SCALE + WQ_HALF) / WQ_DEN);
   localparam logic signed [COEF_BITS-1:0] K4 =
      COEF_BITS'((longint'(353553385) * WQ_SCALE + WQ_HALF) / WQ_DEN);
   localparam logic signed [COEF_BITS-1:0] K5 =
      COEF_BITS'((longint'(277785122) * WQ_SCALE + WQ_HALF) / WQ_DEN);
   localparam logic signed [COEF_BITS-1:0] K6 =
      COEF_BITS'((longint'(191341713) * WQ_SCALE + WQ_HALF) / WQ_DEN);
   localparam logic signed [COEF_BITS-1:0] K7 =
      COEF_BITS'((longint'(97545162) * WQ_SCALE + WQ_HALF) / WQ_DEN);

   // dct-ii basis, row-major (row = frequency, column = sample)
   localparam logic signed [COEF_BITS-1:0] BASIS [N_TERMS] = '{
       K4,  K4,  K4,  K4,  K4,  K4,  K4,  K4,
       K1,  K3,  K5,  K7, -K7, -K5, -K3, -K1,
       K2,  K6, -K6, -K2, -K2, -K6,  K6,  K2,
       K3, -K7, -K1, -K5,  K5,  K1,  K7, -K3,
       K4, -K4, -K4,  K4,  K4, -K4, -K4,  K4,
       K5, -K1,  K7,  K3, -K3, -K7,  K1, -K5,
       K6, -K2,  K2, -K6, -K6,  K2, -K2,  K6,
       K7, -K5,  K3, -K1,  K1, -K3,  K5, -K7
   };

   // rounding and saturation constants
   localparam logic signed [RND_BITS-1:0] RND_HALF =
      RND_BITS'(longint'(1) << (COEF_FRAC_BITS - 1));
   localparam logic signed [RND_BITS-1:0] RND_MAX =
      RND_BITS'((longint'(1) << (OUT_BITS - 1)) - 1);
   localparam logic signed [RND_BITS-1:0] RND_MIN =
      RND_BITS'(-(longint'(1) << (OUT_BITS - 1)));

   // vector types
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [PART_BITS-1:0]   part_type;
   typedef logic signed [OUT_BITS-1:0]    result_type;

   typedef sample_type sample_vec_type [N_POINTS];
   typedef prod_type   prod_vec_type   [N_TERMS];
   typedef part_type   part_vec_type   [N_PARTS];
   typedef result_type result_vec_type [N_POINTS];

endpackage

// ----- design/dct8_product.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct8_product
// Weight selection and the sixty-four constant multiplies. The opcode picks
// the basis matrix or its transpose.
// ----------------------------------------------------------------------------
module dct8_product (
   input  logic                   opcode,
   input  dct8_pkg::sample_vec_type samples,
   output dct8_pkg::prod_vec_type   products
);
   import dct8_pkg::*;

   // products[i*8 + j] = weight(i, j) * sample j
   always_comb begin
      for (int i = 0; i < N_POINTS; i++) begin
         for (int j = 0; j < N_POINTS; j++) begin
            if (opcode == OP_INVERSE) begin
               products[i*N_POINTS + j] = PROD_BITS'(samples[j])
                                        * PROD_BITS'(BASIS[j*N_POINTS + i]);
            end else begin
               products[i*N_POINTS + j] = PROD_BITS'(samples[j])
                                        * PROD_BITS'(BASIS[i*N_POINTS + j]);
            end
         end
      end
   end

endmodule

// ----- design/dct8_partial.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct8_partial
// First adder level: each output row is split into two sums of four
// products.
// ----------------------------------------------------------------------------
module dct8_partial (
   input  dct8_pkg::prod_vec_type products,
   output dct8_pkg::part_vec_type parts
);
   import dct8_pkg::*;

   // parts[2*i + h] sums products i*8 + 4*h .. i*8 + 4*h + 3
   always_comb begin
      for (int p = 0; p < N_PARTS; p++) begin
         parts[p] = PART_BITS'(products[p*4])
                  + PART_BITS'(products[p*4 + 1])
                  + PART_BITS'(products[p*4 + 2])
                  + PART_BITS'(products[p*4 + 3]);
      end
   end

endmodule

// ----- design/dct8_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct8_finish
// Final add of the two half sums, rounding to nearest with halves away
// from zero, and saturation to the output width.
// ----------------------------------------------------------------------------
module dct8_finish (
   input  dct8_pkg::part_vec_type   parts,
   output dct8_pkg::result_vec_type results
);
   import dct8_pkg::*;

   logic signed [ACC_BITS-1:0] acc     [N_POINTS];
   logic signed [RND_BITS-1:0] biased  [N_POINTS];
   logic signed [RND_BITS-1:0] rounded [N_POINTS];

   always_comb begin
      for (int i = 0; i < N_POINTS; i++) begin
         // full row sum
         acc[i] = ACC_BITS'(parts[2*i]) + ACC_BITS'(parts[2*i + 1]);
         // half minus one for negatives gives rounding away from zero
         biased[i] = RND_BITS'(acc[i]) + RND_HALF
                   - RND_BITS'({1'b0, acc[i][ACC_BITS-1]});
         rounded[i] = biased[i] >>> COEF_FRAC_BITS;
         // clamp to the result range
         priority if (rounded[i] > RND_MAX) begin
            results[i] = OUT_BITS'(RND_MAX);
         end else if (rounded[i] < RND_MIN) begin
            results[i] = OUT_BITS'(RND_MIN);
         end else begin
            results[i] = OUT_BITS'(rounded[i]);
         end
      end
   end

endmodule

// ----- design/dct8_forward_inverse_core.sv -----
`timescale 1ns / 1ps
// An accepted item moves through the product, half-sum and result registers
// to the rsp_ port. Throughput: one item per cycle while rsp_ready stays high;
// the three register stages each stall on their own, so bubbles are squeezed out.
// Reset: synchronous, active high; clears the stage valid bits only, the
// transform itself holds no state.
// ----------------------------------------------------------------------------
// dct8_forward_inverse_core
// Orthonormal 8-point DCT-II (forward) and DCT-III (inverse) in fixed point,
// as a three-stage pipeline with valid/ready on both sides.
// ----------------------------------------------------------------------------
module dct8_forward_inverse_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_0,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_1,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_2,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_3,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_4,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_5,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_6,
   input  logic signed [dct8_pkg::SAMPLE_BITS-1:0] req_sample_7,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_0,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_1,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_2,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_3,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_4,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_5,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_6,
   output logic signed [dct8_pkg::OUT_BITS-1:0]    rsp_result_7
);
   import dct8_pkg::*;

   sample_vec_type samples;
   prod_vec_type   prod_in;
   prod_vec_type   prod_ff;
   part_vec_type   part_in;
   part_vec_type   part_ff;
   result_vec_type res_in;
   result_vec_type res_ff;

   logic prod_vld_ff, prod_vld_in;
   logic part_vld_ff, part_vld_in;
   logic res_vld_ff,  res_vld_in;
   logic prod_rdy, part_rdy, res_rdy;

   // gather the sample ports
   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;
   assign samples[6] = req_sample_6;
   assign samples[7] = req_sample_7;

   // stage datapaths
   dct8_product u_product (
      .opcode   (req_opcode),
      .samples  (samples),
      .products (prod_in)
   );

   dct8_partial u_partial (
      .products (prod_ff),
      .parts    (part_in)
   );

   dct8_finish u_finish (
      .parts    (part_ff),
      .results  (res_in)
   );

   // per-stage ready: a stage loads when empty or when it hands on its item
   assign res_rdy   = !res_vld_ff  || rsp_ready;
   assign part_rdy  = !part_vld_ff || res_rdy;
   assign prod_rdy  = !prod_vld_ff || part_rdy;
   assign req_ready = prod_rdy;

   // next valid bits
   assign prod_vld_in = prod_rdy ? req_valid   : prod_vld_ff;
   assign part_vld_in = part_rdy ? prod_vld_ff : part_vld_ff;
   assign res_vld_in  = res_rdy  ? part_vld_ff : res_vld_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         part_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         part_vld_ff <= part_vld_in;
         res_vld_ff  <= res_vld_in;
      end
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      if (prod_rdy) begin
         prod_ff <= prod_in;
      end
      if (part_rdy) begin
         part_ff <= part_in;
      end
      if (res_rdy) begin
         res_ff <= res_in;
      end
   end

   // result ports
   assign rsp_valid    = res_vld_ff;
   assign rsp_result_0 = res_ff[0];
   assign rsp_result_1 = res_ff[1];
   assign rsp_result_2 = res_ff[2];
   assign rsp_result_3 = res_ff[3];
   assign rsp_result_4 = res_ff[4];
   assign rsp_result_5 = res_ff[5];
   assign rsp_result_6 = res_ff[6];
   assign rsp_result_7 = res_ff[7];

   // an accepted item lands in the product stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> prod_vld_ff)
      else $error("accepted item missing from product stage");

   // a full, stalled pipeline pushes back on the request side
   assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff && part_vld_ff && res_vld_ff && !rsp_ready |-> !req_ready)
      else $error("full pipeline still accepting items");

   // a stalled half-sum stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      part_vld_ff && !res_rdy |=> part_vld_ff && $stable(part_ff[0]))
      else $error("stalled half-sum stage lost its item");

   // a stalled product stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff && !part_rdy |=> prod_vld_ff && $stable(prod_ff[0]))
      else $error("stalled product stage lost its item");

endmodule
